>>> rtl/core/ssmd_pkg.sv
// shared types, constants and glyph tables of the seven-segment meter display driver
`default_nettype none

package ssmd_pkg;

   localparam int DIGIT_COUNT_DEF   = 4;
   localparam int FRACTION_BITS_DEF = 8;

   localparam int VALUE_W  = 24;
   localparam int SCALE_W  = 7;
   localparam int PROD_W   = VALUE_W + SCALE_W;
   localparam int SUM_W    = PROD_W + 2;
   localparam int NUM_W    = 16;
   localparam int GLYPH_N  = 4;
   localparam int SHOW_W   = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

   // n / 10 == (n * 0xCCCD) >> 19 for every n below 81920
   localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
   localparam int          DIV10_SHIFT = 19;

   localparam logic [7:0] DP_BIT = 8'h80;

   typedef enum logic [1:0] {
      CMD_VOLTAGE = 2'd0,
      CMD_CURRENT = 2'd1,
      CMD_POWER   = 2'd2,
      CMD_TICK    = 2'd3
   } command_type;

   typedef struct packed {
      logic                      tick;
      logic [GLYPH_N-1:0][7:0]   glyphs;
   } ssmd_entry_type;

   function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0:    seg = 8'h3F;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5B;
         4'd3:    seg = 8'h4F;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6D;
         4'd6:    seg = 8'h7D;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7F;
         4'd9:    seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   function automatic logic [7:0] unit_glyph(input command_type cmd);
      logic [7:0] seg;
      unique case (cmd)
         CMD_VOLTAGE: seg = 8'h3E;
         CMD_CURRENT: seg = 8'h77;
         CMD_POWER:   seg = 8'h73;
         default:     seg = 8'h00;
      endcase
      return seg;
   endfunction

   function automatic logic [SCALE_W-1:0] scale_of(input command_type cmd);
      logic [SCALE_W-1:0] s;
      unique case (cmd)
         CMD_VOLTAGE: s = SCALE_W'(10);
         CMD_CURRENT: s = SCALE_W'(1);
         CMD_POWER:   s = SCALE_W'(100);
         default:     s = '0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/seven_segment_meter_display_driver_top.sv
// top level of the seven-segment meter display driver
// a command reaches the queue through the registered front pipeline; a tick's first result
//   beat follows from the back end's output register when the queue is empty
// throughput: format commands one per cycle unless the front pipeline is stalled; a refresh
//   tick makes eight shift beats and a latch beat via the back end's single output register
// reset: digit store blank, scan position zero, all digits off, pipeline and queue empty
`default_nettype none

module seven_segment_meter_display_driver_top #(
   parameter int DIGIT_COUNT   = ssmd_pkg::DIGIT_COUNT_DEF,
   parameter int FRACTION_BITS = ssmd_pkg::FRACTION_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [23:0] value
   input  wire logic [1:0]  req_tuser,   // [1:0] command
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] serial_bit, [1] shift_strobe,
                                         // [2] latch_strobe, [6:3] digit_enable_n, [7] zero
   output logic             rsp_tlast
);
   import ssmd_pkg::*;

   logic           fq_valid, fq_ready, qb_valid, qb_pop;
   ssmd_entry_type fq_entry, qb_entry;
   logic           serial_bit, shift_strobe, latch_strobe;
   logic [SHOW_W-1:0] digit_enable_n;

   ssmd_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_command (command_type'(req_tuser)),
      .in_value   (req_tdata[VALUE_W-1:0]),
      .out_valid  (fq_valid),
      .out_ready  (fq_ready),
      .out_entry  (fq_entry)
   );

   ssmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_entry  (fq_entry),
      .out_valid (qb_valid),
      .out_pop   (qb_pop),
      .out_entry (qb_entry)
   );

   ssmd_back #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (qb_valid),
      .in_pop             (qb_pop),
      .in_entry           (qb_entry),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .out_serial_bit     (serial_bit),
      .out_shift_strobe   (shift_strobe),
      .out_latch_strobe   (latch_strobe),
      .out_digit_enable_n (digit_enable_n),
      .out_last           (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, digit_enable_n, latch_strobe, shift_strobe, serial_bit};

endmodule

`default_nettype wire

>>> rtl/core/ssmd_front.sv
// front pipeline: scales, rounds, saturates and splits a value into segment bytes
`default_nettype none

module ssmd_front #(
   parameter int FRACTION_BITS = ssmd_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire ssmd_pkg::command_type    in_command,
   input  wire logic [ssmd_pkg::VALUE_W-1:0] in_value,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output ssmd_pkg::ssmd_entry_type      out_entry
);
   import ssmd_pkg::*;

   localparam int STAGES = 7;
   localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRACTION_BITS - 1);

   logic [STAGES-1:0] vld_ff, vld_in;
   logic              advance;

   command_type       cmd1_ff, cmd2_ff, cmd3_ff, cmd4_ff, cmd5_ff, cmd6_ff;
   logic [VALUE_W-1:0] value1_ff;
   logic [PROD_W-1:0]  prod2_ff;
   logic [NUM_W-1:0]   num3_ff, num4_ff;
   logic [12:0]        qa4_ff, qa5_ff;
   logic [9:0]         qb5_ff, qb6_ff;
   logic [6:0]         qc6_ff;
   logic [3:0]         d0_5_ff, d0_6_ff, d1_6_ff;
   ssmd_entry_type     entry_ff, entry_in;

   logic [SUM_W-1:0]   rsum;
   logic [NUM_W-1:0]   num_in;
   logic [31:0]        mul_a, mul_b, mul_c;
   logic [3:0]         d0_in, d1_in, d2_in;

   // whole pipe moves together; stalls only when the last stage is held
   assign advance  = !vld_ff[STAGES-1] || out_ready;
   assign in_ready = advance;
   assign vld_in   = {vld_ff[STAGES-2:0], in_valid};

   always_comb begin
      rsum   = SUM_W'(prod2_ff) + HALF;
      num_in = (|rsum[SUM_W-1:FRACTION_BITS+NUM_W]) ? '1 : rsum[FRACTION_BITS+NUM_W-1:FRACTION_BITS];
      mul_a  = 32'(num3_ff) * 32'(DIV10_MUL);
      mul_b  = 32'(qa4_ff) * 32'(DIV10_MUL);
      mul_c  = 32'(qb5_ff) * 32'(DIV10_MUL);
      d0_in  = 4'(num4_ff - 16'(qa4_ff) * 16'd10);
      d1_in  = 4'(qa5_ff - 13'(qb5_ff) * 13'd10);
      d2_in  = 4'(qb6_ff - 10'(qc6_ff) * 10'd10);
   end

   always_comb begin
      entry_in.tick      = (cmd6_ff == CMD_TICK);
      entry_in.glyphs[0] = digit_glyph(d0_6_ff);
      entry_in.glyphs[1] = digit_glyph(d1_6_ff);
      entry_in.glyphs[2] = digit_glyph(d2_in);
      entry_in.glyphs[3] = unit_glyph(cmd6_ff);
      case (cmd6_ff)
         CMD_VOLTAGE: entry_in.glyphs[1] = entry_in.glyphs[1] | DP_BIT;
         CMD_CURRENT: entry_in.glyphs[3] = entry_in.glyphs[3] | DP_BIT;
         CMD_POWER:   entry_in.glyphs[2] = entry_in.glyphs[2] | DP_BIT;
         default:     ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd1_ff   <= in_command;
         value1_ff <= in_value;
         cmd2_ff   <= cmd1_ff;
         prod2_ff  <= PROD_W'(value1_ff) * PROD_W'(scale_of(cmd1_ff));
         cmd3_ff   <= cmd2_ff;
         num3_ff   <= num_in;
         cmd4_ff   <= cmd3_ff;
         num4_ff   <= num3_ff;
         qa4_ff    <= 13'(mul_a >> DIV10_SHIFT);
         cmd5_ff   <= cmd4_ff;
         qa5_ff    <= qa4_ff;
         qb5_ff    <= 10'(mul_b >> DIV10_SHIFT);
         d0_5_ff   <= d0_in;
         cmd6_ff   <= cmd5_ff;
         qb6_ff    <= qb5_ff;
         qc6_ff    <= 7'(mul_c >> DIV10_SHIFT);
         d0_6_ff   <= d0_5_ff;
         d1_6_ff   <= d1_in;
         entry_ff  <= entry_in;
      end
   end

   assign out_valid = vld_ff[STAGES-1];
   assign out_entry = entry_ff;

endmodule

`default_nettype wire

>>> rtl/core/ssmd_queue.sv
// short queue of decoded commands between the front pipeline and the scan sequencer
`default_nettype none

module ssmd_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire ssmd_pkg::ssmd_entry_type in_entry,
   output logic                          out_valid,
   input  wire logic                     out_pop,
   output ssmd_pkg::ssmd_entry_type      out_entry
);
   import ssmd_pkg::*;

   ssmd_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ssmd_back.sv
// back end: digit store, scan position and serial shift-out of one digit per tick
`default_nettype none

module ssmd_back #(
   parameter int DIGIT_COUNT = ssmd_pkg::DIGIT_COUNT_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_pop,
   input  wire ssmd_pkg::ssmd_entry_type in_entry,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic                          out_serial_bit,
   output logic                          out_shift_strobe,
   output logic                          out_latch_strobe,
   output logic [ssmd_pkg::SHOW_W-1:0]   out_digit_enable_n,
   output logic                          out_last
);
   import ssmd_pkg::*;

   localparam int SCAN_W = $clog2(DIGIT_COUNT);
   localparam int WR_N   = (DIGIT_COUNT < GLYPH_N) ? DIGIT_COUNT : GLYPH_N;
   localparam logic [SHOW_W-1:0] SHOW_MASK =
      (DIGIT_COUNT >= SHOW_W) ? '1 : SHOW_W'((1 << DIGIT_COUNT) - 1);

   logic [7:0]        store_ff [DIGIT_COUNT];
   logic [7:0]        store_in [DIGIT_COUNT];
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [SHOW_W-1:0] enables_ff, enables_in, enables_next;
   logic              busy_ff, busy_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [7:0]        shift_ff, shift_in;

   logic              valid_ff, valid_in;
   logic              bit_ff, bit_in, sh_ff, sh_in, la_ff, la_in, last_ff, last_in;
   logic [SHOW_W-1:0] en_ff, en_in;

   logic              out_free, beat_go, latch_beat, pop;

   assign out_free   = !valid_ff || out_ready;
   assign beat_go    = busy_ff && out_free;
   assign latch_beat = beat_go && (cnt_ff == 4'd8);
   // the next command may leave the queue in the same cycle as the latch beat
   assign pop        = in_valid && (!busy_ff || latch_beat);
   assign in_pop     = pop;

   always_comb begin
      for (int i = 0; i < SHOW_W; i++) begin
         enables_next[i] = SHOW_MASK[i] && (int'(scan_ff) != i);
      end
   end

   always_comb begin
      store_in   = store_ff;
      scan_in    = scan_ff;
      enables_in = enables_ff;
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      shift_in   = shift_ff;
      valid_in   = valid_ff && !out_ready;
      bit_in     = bit_ff;
      sh_in      = sh_ff;
      la_in      = la_ff;
      en_in      = en_ff;
      last_in    = last_ff;

      if (beat_go) begin
         valid_in = 1'b1;
         if (latch_beat) begin
            bit_in     = 1'b0;
            sh_in      = 1'b0;
            la_in      = 1'b1;
            en_in      = enables_next;
            last_in    = 1'b1;
            enables_in = enables_next;
            scan_in    = (scan_ff == SCAN_W'(DIGIT_COUNT - 1)) ? '0 : scan_ff + 1'b1;
            busy_in    = 1'b0;
         end else begin
            bit_in   = shift_ff[7];
            sh_in    = 1'b1;
            la_in    = 1'b0;
            en_in    = enables_ff;
            last_in  = 1'b0;
            shift_in = {shift_ff[6:0], 1'b0};
            cnt_in   = cnt_ff + 4'd1;
         end
      end

      if (pop) begin
         if (in_entry.tick) begin
            busy_in  = 1'b1;
            cnt_in   = '0;
            shift_in = store_ff[scan_in];
         end else begin
            for (int i = 0; i < WR_N; i++) begin
               store_in[i] = in_entry.glyphs[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            store_ff[i] <= '0;
         end
         scan_ff    <= '0;
         enables_ff <= SHOW_MASK;
         busy_ff    <= 1'b0;
         cnt_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         store_ff   <= store_in;
         scan_ff    <= scan_in;
         enables_ff <= enables_in;
         busy_ff    <= busy_in;
         cnt_ff     <= cnt_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bit_ff   <= bit_in;
      sh_ff    <= sh_in;
      la_ff    <= la_in;
      en_ff    <= en_in;
      last_ff  <= last_in;
   end

   assign out_valid          = valid_ff;
   assign out_serial_bit     = bit_ff;
   assign out_shift_strobe   = sh_ff;
   assign out_latch_strobe   = la_ff;
   assign out_digit_enable_n = en_ff;
   assign out_last           = last_ff;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the seven-segment meter display driver
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ssmd_pkg::*;

   localparam int LIMIT_CYCLES      = 200_000;
   localparam int RANDOM_ITEMS      = 380;
   localparam int PHASE_LEN         = 127;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int SETTLE_CYCLES     = 40;
   localparam int FRAC              = FRACTION_BITS_DEF;
   localparam int DIGITS            = DIGIT_COUNT_DEF;
   localparam int SAT_LIMIT         = 65535;
   localparam logic [3:0] ENABLE_MASK = 4'((1 << DIGITS) - 1);

   localparam logic [7:0] NUMERAL_SEGS [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };
   localparam logic [7:0] VOLT_SEG  = 8'h3E;
   localparam logic [7:0] AMP_SEG   = 8'h77;
   localparam logic [7:0] POWER_SEG = 8'h73;

   typedef struct {
      command_type cmd;
      logic [23:0] value;
      int          phase;
      bit          drain_first;
   } meter_item_type;

   typedef struct packed {
      logic       last;
      logic [3:0] digit_enable_n;
      logic       latch_strobe;
      logic       shift_strobe;
      logic       serial_bit;
   } segment_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [23:0] value
   logic [1:0]  req_tuser  = '0;   // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] serial_bit, [1] shift_strobe, [2] latch_strobe,
                                   // [6:3] digit_enable_n, [7] zero
   logic        rsp_tlast;

   meter_item_type   pending_items[$];
   segment_beat_type segment_beats_due[$];

   // own copy of the display state
   logic [7:0]  shown_segments [DIGITS];
   int unsigned scan_digit;
   logic [3:0]  lit_enables;

   int beats_due_total  = 0;
   int beats_seen_total = 0;
   int offer_phase      = 0;
   int error_count      = 0;
   int cycle_count      = 0;
   int stall_left       = 0;
   bit long_stall_done  = 1'b0;

   seven_segment_meter_display_driver_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int sender_idle_pct(int phase);
      case (phase)
         0:       return 20;
         1:       return 54;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct(int phase);
      case (phase)
         0:       return 54;
         1:       return 20;
         default: return 0;
      endcase
   endfunction

   function automatic void apply_format(command_type cmd, logic [23:0] value);
      logic [31:0] scale;
      logic [31:0] scaled;
      logic [31:0] rounded;
      int unsigned reading;
      int unsigned dp_at;
      logic [7:0]  unit_seg;
      logic [7:0]  entry [4];
      int i;
      case (cmd)
         CMD_VOLTAGE: begin
            scale = 10;  unit_seg = VOLT_SEG;  dp_at = 1;
         end
         CMD_CURRENT: begin
            scale = 1;   unit_seg = AMP_SEG;   dp_at = 3;
         end
         default: begin
            scale = 100; unit_seg = POWER_SEG; dp_at = 2;
         end
      endcase
      scaled  = 32'(value) * scale;
      rounded = (scaled + (32'd1 << (FRAC - 1))) >> FRAC;
      reading = (rounded > SAT_LIMIT) ? SAT_LIMIT : rounded;
      entry[0] = NUMERAL_SEGS[reading % 10];
      entry[1] = NUMERAL_SEGS[(reading / 10) % 10];
      entry[2] = NUMERAL_SEGS[(reading / 100) % 10];
      entry[3] = unit_seg;
      entry[dp_at] |= DP_BIT;
      // a display with fewer than four digits drops the upper entries
      for (i = 0; i < 4; i++)
         if (i < DIGITS)
            shown_segments[i] = entry[i];
   endfunction

   function automatic void emit_refresh();
      segment_beat_type beat;
      logic [7:0]       seg;
      int k;
      if (scan_digit >= DIGITS)
         scan_digit = 0;
      seg = shown_segments[scan_digit];
      for (k = 7; k >= 0; k--) begin
         beat                = '0;
         beat.serial_bit     = seg[k];
         beat.shift_strobe   = 1'b1;
         beat.digit_enable_n = lit_enables;
         segment_beats_due.push_back(beat);
      end
      // positions past the fourth digit leave all shown enables high
      lit_enables         = ENABLE_MASK & ~(4'b0001 << scan_digit);
      beat                = '0;
      beat.latch_strobe   = 1'b1;
      beat.digit_enable_n = lit_enables;
      beat.last           = 1'b1;
      segment_beats_due.push_back(beat);
      scan_digit       = (scan_digit + 1) % DIGITS;
      beats_due_total += 9;
   endfunction

   function automatic void queue_item(command_type cmd, logic [23:0] value, int phase,
                                      bit drain_first);
      meter_item_type item;
      item.cmd         = cmd;
      item.value       = value;
      item.phase       = phase;
      item.drain_first = drain_first;
      pending_items.push_back(item);
   endfunction

   function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // driver: predicts on every accepted beat, then offers the next item
   always @(posedge clock) begin
      meter_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (command_type'(req_tuser) == CMD_TICK)
               emit_refresh();
            else
               apply_format(command_type'(req_tuser), req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_items[0].drain_first &&
                         beats_seen_total != beats_due_total) begin
               req_tvalid <= 1'b0;
            end else if ($urandom_range(99) < sender_idle_pct(pending_items[0].phase)) begin
               req_tvalid <= 1'b0;
            end else begin
               item = pending_items.pop_front();
               req_tvalid  <= 1'b1;
               req_tdata   <= item.value;
               req_tuser   <= item.cmd;
               offer_phase <= item.phase;
            end
         end
      end
   end

   // monitor: checks result beats in order and paces rsp_tready
   always @(posedge clock) begin
      segment_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_seen_total <= beats_seen_total + 1;
            if (segment_beats_due.size() == 0) begin
               $error("result beat with nothing expected: tdata %h tlast %b",
                      rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = segment_beats_due.pop_front();
               check_field("serial_bit", want.serial_bit, rsp_tdata[0]);
               check_field("shift_strobe", want.shift_strobe, rsp_tdata[1]);
               check_field("latch_strobe", want.latch_strobe, rsp_tdata[2]);
               check_field("digit_enable_n", want.digit_enable_n, rsp_tdata[6:3]);
               check_field("pad", 4'd0, rsp_tdata[7]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         // one long hold-off while the sender runs flat out, so the block backs up
         if (offer_phase == 2 && !long_stall_done) begin
            long_stall_done = 1'b1;
            stall_left      = LONG_STALL_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct(offer_phase));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int          i;
      int          phase;
      command_type cmd;
      logic [23:0] value;

      for (i = 0; i < DIGITS; i++)
         shown_segments[i] = 8'h00;
      scan_digit  = 0;
      lit_enables = ENABLE_MASK;

      // blank display first, one more tick than digits to see the scan wrap
      for (i = 0; i < 5; i++)
         queue_item(CMD_TICK, (i == 0) ? 24'hFFFFFF : 24'h000000, 0, 1'b0);
      // saturation from the largest value
      queue_item(CMD_VOLTAGE, 24'hFFFFFF, 0, 1'b0);
      for (i = 0; i < 4; i++)
         queue_item(CMD_TICK, 24'h000000, 0, 1'b0);
      // just below and exactly at one half
      queue_item(CMD_CURRENT, 24'h00017F, 0, 1'b0);
      queue_item(CMD_CURRENT, 24'h000180, 0, 1'b0);
      for (i = 0; i < 4; i++)
         queue_item(CMD_TICK, 24'h000000, 0, 1'b0);
      queue_item(CMD_POWER, 24'h000000, 0, 1'b0);
      queue_item(CMD_POWER, 24'h0004D2, 0, 1'b0);
      for (i = 0; i < 4; i++)
         queue_item(CMD_TICK, 24'h000000, 0, 1'b0);
      // rounding that crosses the saturation point
      queue_item(CMD_CURRENT, 24'hFFFF7F, 0, 1'b0);
      queue_item(CMD_CURRENT, 24'hFFFF80, 0, 1'b0);
      queue_item(CMD_TICK, 24'h000000, 0, 1'b0);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         phase = (i / PHASE_LEN > 2) ? 2 : i / PHASE_LEN;
         value = 24'($urandom);
         if ($urandom_range(99) < 45) begin
            cmd = CMD_TICK;
         end else begin
            cmd = command_type'($urandom_range(CMD_VOLTAGE, CMD_POWER));
            case ($urandom_range(2))
               0:       value = 24'($urandom_range(0, 24'h1A0000));
               1:       value = {16'($urandom), ($urandom_range(1) ? 8'h80 : 8'h7F)};
               default: ;
            endcase
         end
         queue_item(cmd, value, phase, i == 2 * PHASE_LEN);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || beats_seen_total != beats_due_total);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (segment_beats_due.size() != 0) begin
         $error("%0d result beats never arrived", segment_beats_due.size());
         error_count++;
      end
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
